>>> rtl/spq_pkg.sv
// shared types and codes for the sorted priority queue
// no dependencies; used by the interfaces, spq_cell and sorted_priority_queue_core
package spq_pkg;

    localparam int KEY_WIDTH     = 32;
    localparam int OUT_REF_WIDTH = 9;
    localparam int FILL_WIDTH    = 10;
    localparam int STATUS_WIDTH  = 2;

    typedef enum logic [0:0] {
        ACTION_PUSH = 1'b0,
        ACTION_PULL = 1'b1
    } action_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pull;
    } cell_ctl_t;

endpackage

>>> rtl/spq_if.sv
// request and response channel interfaces for the sorted priority queue
// depends on spq_pkg
interface spq_req_if #(
    parameter int REF_WIDTH = 9
);
    logic                           valid;
    logic                           ready;
    spq_pkg::action_t               action;
    logic [spq_pkg::KEY_WIDTH-1:0]  key;
    logic [REF_WIDTH-1:0]           node_ref;

    modport source (output valid, action, key, node_ref, input ready);
    modport sink   (input valid, action, key, node_ref, output ready);
endinterface

interface spq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [spq_pkg::KEY_WIDTH-1:0]      out_key;
    logic [spq_pkg::OUT_REF_WIDTH-1:0]  out_node_ref;
    spq_pkg::status_t                   status;
    logic [spq_pkg::FILL_WIDTH-1:0]     fill_count;

    modport source (output valid, out_key, out_node_ref, status, fill_count, input ready);
    modport sink   (input valid, out_key, out_node_ref, status, fill_count, output ready);
endinterface

>>> rtl/spq_cell.sv
// one storage cell of the sorted shift chain
// depends on spq_pkg
module spq_cell #(
    parameter int REF_WIDTH = 9
) (
    input  logic                           clk,
    input  spq_pkg::cell_ctl_t             ctl,
    input  logic                           occupied,
    input  logic [spq_pkg::KEY_WIDTH-1:0]  new_key,
    input  logic [REF_WIDTH-1:0]           new_ref,
    input  logic                           left_ins,
    input  logic [spq_pkg::KEY_WIDTH-1:0]  left_key,
    input  logic [REF_WIDTH-1:0]           left_ref,
    input  logic [spq_pkg::KEY_WIDTH-1:0]  right_key,
    input  logic [REF_WIDTH-1:0]           right_ref,
    output logic                           ins,
    output logic [spq_pkg::KEY_WIDTH-1:0]  key,
    output logic [REF_WIDTH-1:0]           node_ref
);

    logic [spq_pkg::KEY_WIDTH-1:0] key_reg, key_next;
    logic [REF_WIDTH-1:0]          ref_reg, ref_next;

    // new entry lands at or left of this cell (equal keys go behind the new one)
    assign ins = !occupied || (key_reg >= new_key);

    always_comb
    begin
        key_next = key_reg;
        ref_next = ref_reg;
        if (ctl.push && ins)
        begin
            if (left_ins)
            begin
                key_next = left_key;
                ref_next = left_ref;
            end
            else
            begin
                key_next = new_key;
                ref_next = new_ref;
            end
        end
        else if (ctl.pull)
        begin
            key_next = right_key;
            ref_next = right_ref;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        ref_reg <= ref_next;
    end

    assign key      = key_reg;
    assign node_ref = ref_reg;

endmodule

>>> rtl/sorted_priority_queue_core.sv
// sorted priority queue: response valid rises in the cycle after a request transfer
// throughput 1 push or pull per cycle while responses are taken; every cell updates in the same cycle
// a response that is not taken holds off the request side until it is drained
// reset (rst_n, async low) clears the fill count and the response valid only;
// cell contents are left undefined and never read beyond the fill count
// depends on spq_pkg, spq_if (spq_req_if, spq_rsp_if) and spq_cell
module sorted_priority_queue_core #(
    parameter int QUEUE_DEPTH = 512,
    parameter int REF_WIDTH   = 9
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int KW      = spq_pkg::KEY_WIDTH;

    // fill count and derived flags
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               full, empty;
    logic               req_xfer;
    spq_pkg::cell_ctl_t ctl;

    // response register
    logic                              rsp_valid_reg, rsp_valid_next;
    logic [KW-1:0]                     rsp_key_reg, rsp_key_next;
    logic [spq_pkg::OUT_REF_WIDTH-1:0] rsp_ref_reg, rsp_ref_next;
    spq_pkg::status_t                  rsp_status_reg, rsp_status_next;
    logic [spq_pkg::FILL_WIDTH-1:0]    rsp_fill_reg, rsp_fill_next;

    // chain wiring
    logic [KW-1:0]        cell_key [QUEUE_DEPTH];
    logic [REF_WIDTH-1:0] cell_ref [QUEUE_DEPTH];
    logic                 cell_ins [QUEUE_DEPTH];

    // width adapters for head ref and fill count
    logic [REF_WIDTH+spq_pkg::OUT_REF_WIDTH-1:0] head_ref_wide;
    logic [COUNT_W+spq_pkg::FILL_WIDTH-1:0]      count_wide;

    assign full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // accept whenever the response slot is free or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_xfer  = req.valid && req.ready;

    assign ctl.push = req_xfer && (req.action == spq_pkg::ACTION_PUSH) && !full;
    assign ctl.pull = req_xfer && (req.action == spq_pkg::ACTION_PULL) && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
            count_next = count_reg + COUNT_W'(1);
        else if (ctl.pull)
            count_next = count_reg - COUNT_W'(1);
    end

    // the row of cells: head at index 0, new entries shift right, pulls shift left
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                 left_ins;
            logic [KW-1:0]        left_key, right_key;
            logic [REF_WIDTH-1:0] left_ref, right_ref;
            logic                 occupied;

            assign occupied = (COUNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_ins = 1'b0;
                assign left_key = req.key;
                assign left_ref = req.node_ref;
            end
            else
            begin : g_body
                assign left_ins = cell_ins[gi-1];
                assign left_key = cell_key[gi-1];
                assign left_ref = cell_ref[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                // tail holds on pull; it falls outside the fill count anyway
                assign right_key = cell_key[gi];
                assign right_ref = cell_ref[gi];
            end
            else
            begin : g_next
                assign right_key = cell_key[gi+1];
                assign right_ref = cell_ref[gi+1];
            end

            spq_cell #(
                .REF_WIDTH (REF_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (occupied),
                .new_key   (req.key),
                .new_ref   (req.node_ref),
                .left_ins  (left_ins),
                .left_key  (left_key),
                .left_ref  (left_ref),
                .right_key (right_key),
                .right_ref (right_ref),
                .ins       (cell_ins[gi]),
                .key       (cell_key[gi]),
                .node_ref  (cell_ref[gi])
            );
        end
    endgenerate

    assign head_ref_wide = {{spq_pkg::OUT_REF_WIDTH{1'b0}}, cell_ref[0]};
    assign count_wide    = {{spq_pkg::FILL_WIDTH{1'b0}}, count_next};

    // response payload for the current transfer
    always_comb
    begin
        rsp_key_next    = '0;
        rsp_ref_next    = '0;
        rsp_status_next = spq_pkg::STATUS_OK;
        if (req.action == spq_pkg::ACTION_PUSH)
        begin
            if (full)
                rsp_status_next = spq_pkg::STATUS_FULL;
        end
        else if (empty)
        begin
            rsp_status_next = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            rsp_key_next = cell_key[0];
            rsp_ref_next = head_ref_wide[spq_pkg::OUT_REF_WIDTH-1:0];
        end
        rsp_fill_next = count_wide[spq_pkg::FILL_WIDTH-1:0];
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_xfer)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload loads only on a request transfer
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            rsp_key_reg    <= rsp_key_next;
            rsp_ref_reg    <= rsp_ref_next;
            rsp_status_reg <= rsp_status_next;
            rsp_fill_reg   <= rsp_fill_next;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.out_key      = rsp_key_reg;
    assign rsp.out_node_ref = rsp_ref_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.fill_count   = rsp_fill_reg;

endmodule
